FILE: rtl/core/rpl_trickle_dio_timer_defines.svh
// Assertion macros used by the checker of the trickle DIO timer.
`ifndef RPL_TRICKLE_DIO_TIMER_DEFINES_SVH
`define RPL_TRICKLE_DIO_TIMER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RTDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RTDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rtdt_pkg.sv
// Shared constants, codes and types of the trickle DIO timer.
`default_nettype none

package rtdt_pkg;

    localparam int INTERVAL_BITS_DEF = 28;
    localparam int DIS_PERIOD_DEF    = 5;
    localparam int DRAW_BITS         = 16;

    localparam logic [15:0] RANK_INF   = 16'hFFFF;
    localparam logic [15:0] ETX_INF    = 16'd10000;
    localparam logic [15:0] LFSR_RESET = 16'd44257;

    localparam logic [7:0] MIN_INTERVAL_RESET = 8'd5;
    localparam logic [4:0] DOUBLINGS_RESET    = 5'd16;
    localparam logic [7:0] REDUNDANCY_K_RESET = 8'd1;
    localparam logic [7:0] COUNT_MAX          = 8'hFF;

    // Input operation codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_DIO   = 2'd1;
    localparam logic [1:0] OP_DIS   = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_INTERVAL = 3'd0;
    localparam logic [2:0] CFG_DOUBLINGS    = 3'd1;
    localparam logic [2:0] CFG_REDUNDANCY_K = 3'd2;
    localparam logic [2:0] CFG_IS_ROOT      = 3'd3;
    localparam logic [2:0] CFG_LFSR_SEED    = 3'd4;

    // Commands from the event decoder to the trickle timer.
    localparam logic [2:0] TCMD_NONE       = 3'd0;
    localparam logic [2:0] TCMD_TICK       = 3'd1;
    localparam logic [2:0] TCMD_CONSIST    = 3'd2;
    localparam logic [2:0] TCMD_START      = 3'd3;
    localparam logic [2:0] TCMD_START_IDLE = 3'd4;
    localparam logic [2:0] TCMD_STOP       = 3'd5;

    typedef struct packed {
        logic       go;
        logic [2:0] code;
    } t_tmr_cmd;

    typedef struct packed {
        logic done;
        logic bcast;
    } t_tmr_stat;

    typedef struct packed {
        logic [7:0] min_interval;
        logic [4:0] doublings;
        logic [7:0] redundancy_k;
    } t_tmr_cfg;

endpackage

`default_nettype wire

FILE: rtl/core/rtdt_moddiv.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring step.
`default_nettype none

module rtdt_moddiv import rtdt_pkg::*; #(
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DRAW_BITS-1:0]     i_dividend,
    input  logic [INTERVAL_BITS-1:0] i_divisor,
    output logic                     o_done,
    output logic [DRAW_BITS-1:0]     o_rem
);

    localparam int CW       = INTERVAL_BITS + 1;
    localparam int CNT_BITS = $clog2(DRAW_BITS);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [DRAW_BITS-1:0]     r_dvd;
    logic [DRAW_BITS-1:0]     r_rem;
    logic [INTERVAL_BITS-1:0] r_dsr;

    logic [DRAW_BITS:0]   trial;
    logic [CW-1:0]        trial_ext;
    logic [CW-1:0]        dsr_ext;
    logic [CW-1:0]        diff;
    logic [DRAW_BITS-1:0] n_rem;

    // The partial remainder never exceeds the dividend prefix, so it fits the draw width.
    always_comb begin
        trial     = {r_rem, r_dvd[DRAW_BITS-1]};
        trial_ext = CW'(trial);
        dsr_ext   = CW'(r_dsr);
        diff      = trial_ext - dsr_ext;
        if (trial_ext >= dsr_ext) begin
            n_rem = diff[DRAW_BITS-1:0];
        end else begin
            n_rem = trial[DRAW_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DRAW_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DRAW_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/core/rtdt_trickle.sv
// Trickle interval state, random generator and draw sequencing.
`default_nettype none

module rtdt_trickle import rtdt_pkg::*; #(
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tmr_cfg                 i_cfg,
    input  logic                     i_seed_wr,
    input  logic [DRAW_BITS-1:0]     i_seed,
    input  t_tmr_cmd                 i_cmd,
    output t_tmr_stat                o_stat,
    output logic [INTERVAL_BITS-1:0] o_interval
);

    localparam int SW = INTERVAL_BITS + 8;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_IVL  = 2'd1;
    localparam logic [1:0] T_PICK = 2'd2;
    localparam logic [1:0] T_FIRE = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [INTERVAL_BITS-1:0] r_interval, n_interval;
    logic [INTERVAL_BITS-1:0] r_fire, n_fire;
    logic [INTERVAL_BITS-1:0] r_elapsed, n_elapsed;
    logic [7:0]               r_count, n_count;
    logic                     r_running, n_running;
    logic [DRAW_BITS-1:0]     r_lfsr, n_lfsr;
    logic                     r_done, n_done;
    logic                     r_bcast, n_bcast;

    logic [7:0]               imin;
    logic [SW-1:0]            shl;
    logic                     sat;
    logic [INTERVAL_BITS-1:0] imax;
    logic [INTERVAL_BITS-1:0] lo;
    logic [INTERVAL_BITS-1:0] ivl_span;
    logic [INTERVAL_BITS-1:0] half;
    logic [INTERVAL_BITS-1:0] span;
    logic [INTERVAL_BITS-1:0] inc;
    logic [INTERVAL_BITS:0]   dbl;
    logic [INTERVAL_BITS-1:0] grown;
    logic                     fb;
    logic [DRAW_BITS-1:0]     lfsr_next;
    logic                     div_start;
    logic [INTERVAL_BITS-1:0] div_divisor;
    logic                     div_done;
    logic [DRAW_BITS-1:0]     div_rem;

    // Bounds follow the configuration; the user changes it only while idle, unenforced.
    always_comb begin
        imin = (i_cfg.min_interval == 8'd0) ? 8'd1 : i_cfg.min_interval;
        shl  = SW'(imin) << i_cfg.doublings;
        sat  = ({1'b0, i_cfg.doublings} >= 6'(INTERVAL_BITS))
            || (shl[SW-1:INTERVAL_BITS] != '0);
        imax = sat ? '1 : shl[INTERVAL_BITS-1:0];
        lo   = (INTERVAL_BITS'(imin) > imax) ? imax : INTERVAL_BITS'(imin);
        ivl_span = imax - lo + INTERVAL_BITS'(1);

        half = r_interval >> 1;
        span = r_interval - half;
        if (span == '0) begin
            span = INTERVAL_BITS'(1);
        end

        inc = r_elapsed + INTERVAL_BITS'(1);
        dbl = {r_interval, 1'b0};
        grown = (dbl < {1'b0, imax}) ? dbl[INTERVAL_BITS-1:0] : imax;
        if (grown == '0) begin
            grown = imax;
        end

        fb        = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];
        lfsr_next = {fb, r_lfsr[DRAW_BITS-1:1]};
    end

    always_comb begin
        n_state     = r_state;
        n_interval  = r_interval;
        n_fire      = r_fire;
        n_elapsed   = r_elapsed;
        n_count     = r_count;
        n_running   = r_running;
        n_lfsr      = r_lfsr;
        n_done      = 1'b0;
        n_bcast     = r_bcast;
        div_start   = 1'b0;
        div_divisor = span;

        case (r_state)
            T_IDLE: begin
                if (i_cmd.go) begin
                    n_bcast = 1'b0;
                    case (i_cmd.code)
                        TCMD_TICK: begin
                            n_done = 1'b1;
                            if (r_running) begin
                                n_bcast = (inc == r_fire) && (r_count < i_cfg.redundancy_k);
                                if (inc >= r_interval) begin
                                    // Interval over: grow it and draw a new fire point.
                                    n_interval = grown;
                                    n_count    = '0;
                                    n_elapsed  = '0;
                                    n_done     = 1'b0;
                                    n_state    = T_PICK;
                                end else begin
                                    n_elapsed = inc;
                                end
                            end
                        end
                        TCMD_CONSIST: begin
                            n_done = 1'b1;
                            if (r_count != COUNT_MAX) begin
                                n_count = r_count + 8'd1;
                            end
                        end
                        TCMD_START, TCMD_START_IDLE: begin
                            if ((i_cmd.code == TCMD_START) || !r_running) begin
                                div_start   = 1'b1;
                                div_divisor = ivl_span;
                                n_lfsr      = lfsr_next;
                                n_state     = T_IVL;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        TCMD_STOP: begin
                            n_interval = '0;
                            n_fire     = '0;
                            n_elapsed  = '0;
                            n_count    = '0;
                            n_running  = 1'b0;
                            n_done     = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            T_IVL: begin
                if (div_done) begin
                    n_interval = lo + INTERVAL_BITS'(div_rem);
                    n_count    = '0;
                    n_elapsed  = '0;
                    n_state    = T_PICK;
                end
            end
            T_PICK: begin
                div_start = 1'b1;
                n_lfsr    = lfsr_next;
                n_state   = T_FIRE;
            end
            T_FIRE: begin
                if (div_done) begin
                    n_fire    = INTERVAL_BITS'(div_rem) + half + INTERVAL_BITS'(1);
                    n_running = 1'b1;
                    n_done    = 1'b1;
                    n_state   = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase

        if (i_seed_wr) begin
            n_lfsr = (i_seed == '0) ? DRAW_BITS'(1) : i_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_IDLE;
            r_interval <= '0;
            r_fire     <= '0;
            r_elapsed  <= '0;
            r_count    <= '0;
            r_running  <= 1'b0;
            r_lfsr     <= LFSR_RESET;
            r_done     <= 1'b0;
            r_bcast    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_interval <= n_interval;
            r_fire     <= n_fire;
            r_elapsed  <= n_elapsed;
            r_count    <= n_count;
            r_running  <= n_running;
            r_lfsr     <= n_lfsr;
            r_done     <= n_done;
            r_bcast    <= n_bcast;
        end
    end

    rtdt_moddiv #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_moddiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lfsr_next),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_stat.done  = r_done;
    assign o_stat.bcast = r_bcast;
    assign o_interval   = r_interval;

endmodule

`default_nettype wire

FILE: rtl/core/rpl_trickle_dio_timer.sv
// Trickle timer for DIO pacing with rank bookkeeping, top level.
// A plain tick, DIO count or DIS passes the timer command register, the timer's done
// flag and the push state into the output register; an interval end adds one random draw
// and a (re)start two. Each draw is a bit-serial remainder over the 16 random bits: a load,
// then one bit a cycle. One item at a time, and an output stall holds the push state; the next
// item is accepted once its result is in the output register. Synchronous active-low reset.
`default_nettype none

module rpl_trickle_dio_timer import rtdt_pkg::*; #(
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
    parameter int DIS_PERIOD    = DIS_PERIOD_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [2:0]               i_cfg_index,
    input  logic [15:0]              i_cfg_data,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [15:0]              i_parent_rank,
    input  logic [15:0]              i_parent_etx,
    input  logic [7:0]               i_parent_version,
    input  logic [63:0]              i_dodag_id_high,
    input  logic [63:0]              i_dodag_id_low,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_send_dio_broadcast,
    output logic                     o_send_dio_unicast,
    output logic                     o_send_dis_multicast,
    output logic                     o_add_parent,
    output logic                     o_new_preferred_parent,
    output logic [15:0]              o_own_rank,
    output logic [15:0]              o_own_etx,
    output logic                     o_grounded,
    output logic [INTERVAL_BITS-1:0] o_interval_now
);

    localparam logic [2:0] DIS_RELOAD = 3'(DIS_PERIOD);

    // Item sequencing: take an item, let the timer work, then hand the result on.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WORK = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]  r_state;

    // Configuration registers. The seed is not kept: a write loads the generator directly.
    logic [7:0]  r_min_interval;
    logic [4:0]  r_doublings;
    logic [7:0]  r_redundancy_k;
    logic        r_is_root;

    // Node bookkeeping.
    logic [15:0] r_rank, n_rank;
    logic [15:0] r_etx, n_etx;
    logic [7:0]  r_version, n_version;
    logic [63:0] r_dodag_hi, n_dodag_hi;
    logic [63:0] r_dodag_lo, n_dodag_lo;
    logic        r_grounded, n_grounded;
    logic        r_dis_active, n_dis_active;
    logic [2:0]  r_dis_cd, n_dis_cd;

    // Flags of the item in flight.
    logic        r_ucast, n_ucast;
    logic        r_dis, n_dis;
    logic        r_addp, n_addp;
    logic        r_newp, n_newp;
    logic        r_bcast;
    logic [2:0]  n_code;
    t_tmr_cmd    r_cmd;

    // Output register.
    logic        r_out_valid;
    logic        r_out_bcast;
    logic        r_out_ucast;
    logic        r_out_dis;
    logic        r_out_addp;
    logic        r_out_newp;
    logic [15:0] r_out_rank;
    logic [15:0] r_out_etx;
    logic        r_out_grounded;
    logic [INTERVAL_BITS-1:0] r_out_interval;

    logic                     in_acc;
    logic                     out_load;
    logic [16:0]              pr1;
    logic [16:0]              pe1;
    logic                     seed_wr;
    t_tmr_cfg                 tmr_cfg;
    t_tmr_stat                tmr_stat;
    logic [INTERVAL_BITS-1:0] interval;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_PUSH) && (!r_out_valid || !i_out_stall);
    assign seed_wr  = i_cfg_valid && (i_cfg_index == CFG_LFSR_SEED);

    assign tmr_cfg.min_interval = r_min_interval;
    assign tmr_cfg.doublings    = r_doublings;
    assign tmr_cfg.redundancy_k = r_redundancy_k;

    // Decode of an item. The node state changes at accept; the timer command
    // is registered for the cycle after, and its broadcast flag comes back with done.
    always_comb begin
        n_rank       = r_rank;
        n_etx        = r_etx;
        n_version    = r_version;
        n_dodag_hi   = r_dodag_hi;
        n_dodag_lo   = r_dodag_lo;
        n_grounded   = r_grounded;
        n_dis_active = r_dis_active;
        n_dis_cd     = r_dis_cd;
        n_ucast      = 1'b0;
        n_dis        = 1'b0;
        n_addp       = 1'b0;
        n_newp       = 1'b0;
        n_code       = TCMD_NONE;

        pr1 = {1'b0, i_parent_rank} + 17'd1;
        pe1 = {1'b0, i_parent_etx} + 17'd1;

        case (i_op)
            OP_TICK: begin
                n_code = TCMD_TICK;
                // A floating node repeats its DIS every DIS_PERIOD ticks.
                if (r_dis_active) begin
                    if (r_dis_cd <= 3'd1) begin
                        n_dis    = 1'b1;
                        n_dis_cd = DIS_RELOAD;
                    end else begin
                        n_dis_cd = r_dis_cd - 3'd1;
                    end
                end
            end
            OP_DIO: begin
                n_dis_active = 1'b0;
                n_dis_cd     = '0;
                // The root ignores DIOs.
                if (r_rank > 16'd1) begin
                    n_addp = (i_parent_rank < r_rank);
                    if ((r_rank == RANK_INF) || ({1'b0, r_rank} > pr1)) begin
                        // Better parent: adopt it and restart the timer.
                        n_newp     = 1'b1;
                        n_rank     = pr1[16] ? RANK_INF : pr1[15:0];
                        n_etx      = pe1[16] ? 16'hFFFF : pe1[15:0];
                        n_version  = i_parent_version;
                        n_dodag_hi = i_dodag_id_high;
                        n_dodag_lo = i_dodag_id_low;
                        n_grounded = 1'b1;
                        n_code     = TCMD_START;
                    end else begin
                        n_code = TCMD_CONSIST;
                    end
                end
            end
            OP_DIS: begin
                if (r_grounded) begin
                    n_ucast = 1'b1;
                    n_code  = TCMD_START_IDLE;
                end
            end
            OP_START: begin
                n_code = TCMD_STOP;
                if (r_is_root) begin
                    n_rank       = 16'd1;
                    n_etx        = 16'd0;
                    n_version    = 8'd1;
                    n_grounded   = 1'b1;
                    n_dis_active = 1'b0;
                    n_dis_cd     = '0;
                end else begin
                    n_rank       = RANK_INF;
                    n_etx        = ETX_INF;
                    n_version    = 8'd0;
                    n_dodag_hi   = '1;
                    n_dodag_lo   = '1;
                    n_grounded   = 1'b0;
                    n_dis_active = 1'b1;
                    n_dis        = 1'b1;
                    n_dis_cd     = DIS_RELOAD;
                end
            end
            default: begin
                n_code = TCMD_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_min_interval <= MIN_INTERVAL_RESET;
            r_doublings    <= DOUBLINGS_RESET;
            r_redundancy_k <= REDUNDANCY_K_RESET;
            r_is_root      <= 1'b0;
            r_rank         <= RANK_INF;
            r_etx          <= ETX_INF;
            r_version      <= 8'd0;
            r_dodag_hi     <= '1;
            r_dodag_lo     <= '1;
            r_grounded     <= 1'b0;
            r_dis_active   <= 1'b0;
            r_dis_cd       <= '0;
            r_cmd          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[7:0];
                    CFG_DOUBLINGS:    r_doublings    <= i_cfg_data[4:0];
                    CFG_REDUNDANCY_K: r_redundancy_k <= i_cfg_data[7:0];
                    CFG_IS_ROOT:      r_is_root      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // The timer command is a one-cycle pulse for each accepted item.
            r_cmd.go   <= in_acc;
            r_cmd.code <= n_code;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rank       <= n_rank;
                        r_etx        <= n_etx;
                        r_version    <= n_version;
                        r_dodag_hi   <= n_dodag_hi;
                        r_dodag_lo   <= n_dodag_lo;
                        r_grounded   <= n_grounded;
                        r_dis_active <= n_dis_active;
                        r_dis_cd     <= n_dis_cd;
                        r_state      <= S_WORK;
                    end
                end
                S_WORK: begin
                    if (tmr_stat.done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ucast <= n_ucast;
            r_dis   <= n_dis;
            r_addp  <= n_addp;
            r_newp  <= n_newp;
        end
        if ((r_state == S_WORK) && tmr_stat.done) begin
            r_bcast <= tmr_stat.bcast;
        end
        if (out_load) begin
            r_out_bcast    <= r_bcast;
            r_out_ucast    <= r_ucast;
            r_out_dis      <= r_dis;
            r_out_addp     <= r_addp;
            r_out_newp     <= r_newp;
            r_out_rank     <= r_rank;
            r_out_etx      <= r_etx;
            r_out_grounded <= r_grounded;
            r_out_interval <= interval;
        end
    end

    rtdt_trickle #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_trickle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (tmr_cfg),
        .i_seed_wr  (seed_wr),
        .i_seed     (i_cfg_data),
        .i_cmd      (r_cmd),
        .o_stat     (tmr_stat),
        .o_interval (interval)
    );

    assign o_cfg_ready            = 1'b1;
    assign o_in_stall             = (r_state != S_IDLE);
    assign o_out_valid            = r_out_valid;
    assign o_send_dio_broadcast   = r_out_bcast;
    assign o_send_dio_unicast     = r_out_ucast;
    assign o_send_dis_multicast   = r_out_dis;
    assign o_add_parent           = r_out_addp;
    assign o_new_preferred_parent = r_out_newp;
    assign o_own_rank             = r_out_rank;
    assign o_own_etx              = r_out_etx;
    assign o_grounded             = r_out_grounded;
    assign o_interval_now         = r_out_interval;

endmodule

`default_nettype wire

FILE: rtl/core/rtdt_checker.sv
// Port-level checker of the trickle DIO timer and its bind to the top level.
`default_nettype none
`include "rpl_trickle_dio_timer_defines.svh"

module rtdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_send_dio_unicast,
    input logic        o_send_dis_multicast,
    input logic        o_new_preferred_parent,
    input logic [15:0] o_own_rank,
    input logic        o_grounded
);

    // Only a node attached to a DODAG answers a DIS.
    `RTDT_ASSERT_SAME(a_ucast_grounded, i_clk, i_rst_n, o_out_valid && o_send_dio_unicast, o_grounded, "unicast DIO from a floating node")

    // Adopting a parent attaches the node.
    `RTDT_ASSERT_SAME(a_newp_grounded, i_clk, i_rst_n, o_out_valid && o_new_preferred_parent, o_grounded, "new parent but node not grounded")

    // A DIS is only multicast by a floating node with infinite rank.
    `RTDT_ASSERT_SAME(a_dis_floating, i_clk, i_rst_n, o_out_valid && o_send_dis_multicast, !o_grounded && (o_own_rank == 16'hFFFF), "DIS multicast from an attached node")

    // A stalled result stays on the port.
    `RTDT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_own_rank) && $stable(o_grounded), "stalled result changed")

endmodule

bind rpl_trickle_dio_timer rtdt_checker u_rtdt_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .o_out_valid            (o_out_valid),
    .i_out_stall            (i_out_stall),
    .o_send_dio_unicast     (o_send_dio_unicast),
    .o_send_dis_multicast   (o_send_dis_multicast),
    .o_new_preferred_parent (o_new_preferred_parent),
    .o_own_rank             (o_own_rank),
    .o_grounded             (o_grounded)
);

`default_nettype wire

FILE: tb/rpl_trickle_dio_timer_test.sv
// Self-checking regression bench for the trickle DIO timer with rank bookkeeping.

module rpl_trickle_dio_timer_test;
    import rtdt_pkg::*;

    localparam int IB = INTERVAL_BITS_DEF;
    localparam logic [63:0] INTERVAL_MASK = (64'd1 << IB) - 64'd1;
    localparam logic [2:0] DIS_RELOAD = 3'(DIS_PERIOD_DEF & 7);
    // Index 7 has no register behind it; a write there must leave every setting alone.
    localparam logic [2:0] CFG_SPARE = 3'd7;
    localparam int RANDOM_PHASES = 6;
    localparam int RANDOM_ITEMS = 40;
    localparam int FLOOD_ITEMS = 260;
    localparam int TAIL_CYCLES = 60;
    localparam int RUN_LIMIT = 3_000_000;

    // One event offered to the block, and the status item that it causes.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] prank;
        logic [15:0] petx;
        logic [7:0]  pver;
        logic [63:0] id_hi;
        logic [63:0] id_lo;
    } t_node_event;

    typedef struct packed {
        logic          bcast;
        logic          ucast;
        logic          dis;
        logic          addp;
        logic          newp;
        logic [15:0]   rank;
        logic [15:0]   etx;
        logic          grounded;
        logic [IB-1:0] interval;
    } t_node_report;

    // Every input of the block starts at a known value.
    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic [2:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data = '0;
    logic          i_in_valid = 1'b0;
    logic [1:0]    i_op = OP_TICK;
    logic [15:0]   i_parent_rank = '0;
    logic [15:0]   i_parent_etx = '0;
    logic [7:0]    i_parent_version = '0;
    logic [63:0]   i_dodag_id_high = '0;
    logic [63:0]   i_dodag_id_low = '0;
    logic          i_out_stall = 1'b0;
    logic          o_cfg_ready;
    logic          o_in_stall;
    logic          o_out_valid;
    logic          o_send_dio_broadcast;
    logic          o_send_dio_unicast;
    logic          o_send_dis_multicast;
    logic          o_add_parent;
    logic          o_new_preferred_parent;
    logic [15:0]   o_own_rank;
    logic [15:0]   o_own_etx;
    logic          o_grounded;
    logic [IB-1:0] o_interval_now;

    rpl_trickle_dio_timer u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Events waiting to be offered, and status items waiting to come back.
    t_node_event  event_backlog[$];
    t_node_report awaited_status[$];

    // Shadow copy of the settings, as last written through the configuration port.
    logic [7:0]  cfg_imin = MIN_INTERVAL_RESET;
    logic [4:0]  cfg_dbl = DOUBLINGS_RESET;
    logic [7:0]  cfg_k = REDUNDANCY_K_RESET;
    logic        cfg_root = 1'b0;

    // Shadow copy of the node: trickle timer, DIS pacing, rank and DODAG data.
    logic [63:0] tmr_len = '0;
    logic [63:0] tmr_fire = '0;
    logic [63:0] tmr_elapsed = '0;
    logic [7:0]  tmr_heard = '0;
    logic        tmr_on = 1'b0;
    logic        dis_on = 1'b0;
    logic [2:0]  dis_left = '0;
    logic [15:0] node_rank = RANK_INF;
    logic [15:0] node_etx = ETX_INF;
    logic [7:0]  node_version = '0;
    logic [63:0] node_dodag_hi = '1;
    logic [63:0] node_dodag_lo = '1;
    logic        node_grounded = 1'b0;
    logic [15:0] lfsr_q = LFSR_RESET;

    // Idling odds on each side; zero means the side never idles.
    int in_odds = 2;
    int out_odds = 2;
    int in_gap = 0;
    int out_hold = 0;

    int faults = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int setting_count = 1;
    int bcast_count = 0;
    int ucast_count = 0;
    int dis_count = 0;

    // The generator is a 16-bit Fibonacci LFSR; each draw shifts once and the new
    // register value is the random number.
    function automatic logic [15:0] lfsr_next();
        logic fb;
        fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
        lfsr_q = {fb, lfsr_q[15:1]};
        return lfsr_q;
    endfunction

    // A minimum interval of zero behaves as one tick.
    function automatic logic [63:0] floor_interval();
        return (cfg_imin == 8'd0) ? 64'd1 : {56'd0, cfg_imin};
    endfunction

    // The largest interval saturates at the widest value the interval counter holds.
    function automatic logic [63:0] ceiling_interval();
        logic [63:0] v;
        v = floor_interval() << cfg_dbl;
        return (v > INTERVAL_MASK) ? INTERVAL_MASK : v;
    endfunction

    // The fire point falls in the second half of the interval, [i/2+1, i].
    function automatic void place_fire_point();
        logic [63:0] half;
        logic [63:0] span;
        half = tmr_len / 2;
        span = tmr_len - half;
        if (span == 0)
            span = 64'd1;
        tmr_fire = (({48'd0, lfsr_next()} % span) + half + 1) & INTERVAL_MASK;
    endfunction

    // A fresh timer draws its first interval from [imin, imax], then its fire point.
    function automatic void restart_trickle();
        logic [63:0] lo;
        logic [63:0] hi;
        lo = floor_interval();
        hi = ceiling_interval();
        if (lo > hi)
            lo = hi;
        tmr_len = lo + ({48'd0, lfsr_next()} % (hi - lo + 1));
        tmr_heard = '0;
        tmr_elapsed = '0;
        place_fire_point();
        tmr_on = 1'b1;
    endfunction

    // Applies one event to the shadow node and returns the status that it should report.
    function automatic t_node_report advance_node(input t_node_event ev);
        t_node_report rep;
        logic [16:0]  up_rank;
        logic [16:0]  up_etx;
        logic [63:0]  hi;
        rep = '0;
        case (ev.op)
            OP_TICK: begin
                // An idle timer keeps its state; only DIS pacing moves on.
                if (tmr_on) begin
                    tmr_elapsed = (tmr_elapsed + 1) & INTERVAL_MASK;
                    if (tmr_elapsed == tmr_fire && tmr_heard < cfg_k)
                        rep.bcast = 1'b1;
                    if (tmr_elapsed >= tmr_len) begin
                        hi = ceiling_interval();
                        tmr_len = (tmr_len * 2 < hi) ? tmr_len * 2 : hi;
                        if (tmr_len == 0)
                            tmr_len = hi;
                        tmr_heard = '0;
                        tmr_elapsed = '0;
                        place_fire_point();
                    end
                end
                if (dis_on) begin
                    if (dis_left <= 3'd1) begin
                        rep.dis = 1'b1;
                        dis_left = DIS_RELOAD;
                    end else begin
                        dis_left = dis_left - 3'd1;
                    end
                end
            end
            OP_DIO: begin
                dis_on = 1'b0;
                dis_left = '0;
                // A node of rank one or less ignores every DIO.
                if (node_rank > 16'd1) begin
                    up_rank = {1'b0, ev.prank} + 17'd1;
                    if (ev.prank < node_rank)
                        rep.addp = 1'b1;
                    if (node_rank == RANK_INF || {1'b0, node_rank} > up_rank) begin
                        rep.newp = 1'b1;
                        node_rank = up_rank[16] ? RANK_INF : up_rank[15:0];
                        up_etx = {1'b0, ev.petx} + 17'd1;
                        node_etx = up_etx[16] ? 16'hFFFF : up_etx[15:0];
                        node_version = ev.pver;
                        node_dodag_hi = ev.id_hi;
                        node_dodag_lo = ev.id_lo;
                        node_grounded = 1'b1;
                        restart_trickle();
                    end else if (tmr_heard < COUNT_MAX) begin
                        tmr_heard = tmr_heard + 8'd1;
                    end
                end
            end
            OP_DIS: begin
                // Only a grounded node answers, and it wakes an idle timer.
                if (node_grounded) begin
                    rep.ucast = 1'b1;
                    if (!tmr_on)
                        restart_trickle();
                end
            end
            OP_START: begin
                tmr_len = '0;
                tmr_fire = '0;
                tmr_elapsed = '0;
                tmr_heard = '0;
                tmr_on = 1'b0;
                if (cfg_root) begin
                    // The root keeps its DODAG identifier as it was.
                    node_rank = 16'd1;
                    node_etx = 16'd0;
                    node_version = 8'd1;
                    node_grounded = 1'b1;
                    dis_on = 1'b0;
                    dis_left = '0;
                end else begin
                    node_rank = RANK_INF;
                    node_etx = ETX_INF;
                    node_version = '0;
                    node_dodag_hi = '1;
                    node_dodag_lo = '1;
                    node_grounded = 1'b0;
                    dis_on = 1'b1;
                    rep.dis = 1'b1;
                    dis_left = DIS_RELOAD;
                end
            end
            default: ;
        endcase
        rep.rank = node_rank;
        rep.etx = node_etx;
        rep.grounded = node_grounded;
        rep.interval = tmr_len[IB-1:0];
        return rep;
    endfunction

    // Queues one event; the DIO payload fields the caller does not fix are random.
    function automatic void push_event(input logic [1:0] op, input logic [15:0] rank,
                                       input logic [15:0] etx);
        t_node_event ev;
        ev.op = op;
        ev.prank = rank;
        ev.petx = etx;
        ev.pver = 8'($urandom_range(0, 255));
        ev.id_hi = {$urandom, $urandom};
        ev.id_lo = {$urandom, $urandom};
        event_backlog.push_back(ev);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            faults++;
        end
    endtask

    // Writes one register through its own valid/ready channel and mirrors it in the
    // shadow settings. A seed write also reloads the generator, with zero taken as one.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_INTERVAL: cfg_imin = val[7:0];
            CFG_DOUBLINGS:    cfg_dbl = val[4:0];
            CFG_REDUNDANCY_K: cfg_k = val[7:0];
            CFG_IS_ROOT:      cfg_root = val[0];
            CFG_LFSR_SEED:    lfsr_q = (val == 16'd0) ? 16'd1 : val;
            default: ;
        endcase
    endtask

    // Every event yields exactly one status item, so the block is idle once nothing is
    // queued, nothing is offered and every expected item has come back. Sampling on the
    // falling edge keeps this clear of the clocked blocks below.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (event_backlog.size() != 0 || i_in_valid || awaited_status.size() != 0);
    endtask

    // Driver: offers the next queued event, holds it steady while the block stalls,
    // and records the expected status at the edge where the item is taken.
    always @(posedge i_clk) begin : driver
        t_node_event cur_ev;
        logic        valid_n;
        if (i_rst_n) begin
            valid_n = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                awaited_status.push_back(advance_node(cur_ev));
                accepted_count++;
                valid_n = 1'b0;
                if (in_odds != 0 && $urandom_range(0, in_odds) == 0)
                    in_gap = $urandom_range(1, 12);
            end
            // A new item goes out only once the previous one is taken, so valid never
            // drops while the block is stalling it.
            if (!valid_n) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (event_backlog.size() != 0) begin
                    cur_ev = event_backlog.pop_front();
                    valid_n = 1'b1;
                    i_op <= cur_ev.op;
                    i_parent_rank <= cur_ev.prank;
                    i_parent_etx <= cur_ev.petx;
                    i_parent_version <= cur_ev.pver;
                    i_dodag_id_high <= cur_ev.id_hi;
                    i_dodag_id_low <= cur_ev.id_lo;
                end
            end
            i_in_valid <= valid_n;
        end
    end

    // Monitor: compares each status item taken from the block with the oldest
    // expectation, then decides whether to stall the next cycle.
    always @(posedge i_clk) begin : monitor
        t_node_report want;
        logic         stall_n;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_status.size() == 0) begin
                    $error("status item arrived with no event awaiting it");
                    faults++;
                end else begin
                    want = awaited_status.pop_front();
                    check_field("send_dio_broadcast", 64'(want.bcast),
                                64'(o_send_dio_broadcast));
                    check_field("send_dio_unicast", 64'(want.ucast),
                                64'(o_send_dio_unicast));
                    check_field("send_dis_multicast", 64'(want.dis),
                                64'(o_send_dis_multicast));
                    check_field("add_parent", 64'(want.addp), 64'(o_add_parent));
                    check_field("new_preferred_parent", 64'(want.newp),
                                64'(o_new_preferred_parent));
                    check_field("own_rank", 64'(want.rank), 64'(o_own_rank));
                    check_field("own_etx", 64'(want.etx), 64'(o_own_etx));
                    check_field("grounded", 64'(want.grounded), 64'(o_grounded));
                    check_field("interval_now", 64'(want.interval), 64'(o_interval_now));
                    checked_count++;
                    bcast_count += want.bcast;
                    ucast_count += want.ucast;
                    dis_count += want.dis;
                end
            end
            // Stalls come in bursts of random length, independent of o_out_valid.
            if (out_hold > 0) begin
                out_hold--;
                stall_n = 1'b1;
            end else if (out_odds != 0 && $urandom_range(0, out_odds * 4) == 0) begin
                out_hold = $urandom_range(0, 11);
                stall_n = 1'b1;
            end else begin
                stall_n = 1'b0;
            end
            i_out_stall <= stall_n;
        end
    end

    // Stimulus: a directed opening, a flood of consistent DIOs, then random phases
    // each under its own register settings.
    initial begin : stimulus
        int          pick;
        int          phase;
        logic [1:0]  op_w;
        logic [15:0] rank_w;
        logic [15:0] etx_w;
        logic [15:0] imin_w;
        logic [15:0] dbl_w;
        logic [15:0] k_w;
        logic [15:0] seed_w;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings. A tick with the timer idle and a DIS while floating change
        // nothing. A DIO of rank 65535 saturates rank and etx and still grounds the node
        // because it is floating; a DIO of rank 0 makes the node rank one, after which
        // DIOs are ignored. The start then makes a floating node that sends a DIS.
        @(negedge i_clk);
        push_event(OP_TICK, 16'd0, 16'd0);
        push_event(OP_DIS, 16'd0, 16'd0);
        push_event(OP_DIO, 16'hFFFF, 16'hFFFF);
        push_event(OP_DIS, 16'd0, 16'd0);
        push_event(OP_DIO, 16'd0, 16'd0);
        push_event(OP_DIO, 16'd5, 16'd5);
        push_event(OP_TICK, 16'd0, 16'd0);
        push_event(OP_START, 16'd0, 16'd0);
        wait_drained();

        // Minimum interval zero, doublings at the top of the field so the largest
        // interval saturates, k zero so nothing is broadcast, and a zero seed. The five
        // ticks bring the periodic DIS; then an adoption, a consistent DIO, a better one.
        write_reg(CFG_MIN_INTERVAL, 16'd0);
        write_reg(CFG_DOUBLINGS, 16'd31);
        write_reg(CFG_REDUNDANCY_K, 16'd0);
        write_reg(CFG_IS_ROOT, 16'd0);
        write_reg(CFG_LFSR_SEED, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        setting_count++;
        @(negedge i_clk);
        repeat (5) push_event(OP_TICK, 16'd0, 16'd0);
        push_event(OP_DIO, 16'd10, 16'd0);
        push_event(OP_DIO, 16'd40, 16'd7);
        push_event(OP_DIO, 16'd3, 16'd2);
        push_event(OP_DIS, 16'd0, 16'd0);
        push_event(OP_TICK, 16'd0, 16'd0);
        wait_drained();

        // Largest minimum interval, k at its top, all-ones seed, and a root node: the
        // root ignores DIOs, and a DIS starts its timer.
        write_reg(CFG_MIN_INTERVAL, 16'd255);
        write_reg(CFG_DOUBLINGS, 16'd0);
        write_reg(CFG_REDUNDANCY_K, 16'd255);
        write_reg(CFG_IS_ROOT, 16'd1);
        write_reg(CFG_LFSR_SEED, 16'hFFFF);
        setting_count++;
        @(negedge i_clk);
        push_event(OP_START, 16'd0, 16'd0);
        push_event(OP_DIO, 16'd0, 16'd0);
        push_event(OP_DIS, 16'd0, 16'd0);
        repeat (3) push_event(OP_TICK, 16'd0, 16'd0);
        wait_drained();

        // One-tick intervals with k at 255: after more than 255 consistent DIOs the
        // counter must stick at 255, so the first tick stays silent and the next one,
        // in a fresh interval, broadcasts.
        write_reg(CFG_MIN_INTERVAL, 16'd1);
        write_reg(CFG_REDUNDANCY_K, 16'd255);
        write_reg(CFG_IS_ROOT, 16'd0);
        write_reg(CFG_LFSR_SEED, 16'($urandom_range(1, 65535)));
        setting_count++;
        @(negedge i_clk);
        push_event(OP_START, 16'd0, 16'd0);
        push_event(OP_DIO, 16'($urandom_range(2, 100)), 16'($urandom));
        repeat (FLOOD_ITEMS) push_event(OP_DIO, 16'($urandom_range(60000, 65535)),
                                        16'($urandom));
        repeat (3) push_event(OP_TICK, 16'd0, 16'd0);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            // The last phase runs with both sides always ready.
            if (phase == RANDOM_PHASES - 1) begin
                in_odds = 0;
                out_odds = 0;
            end else begin
                in_odds = $urandom_range(0, 3) * 2;
                out_odds = $urandom_range(0, 3) * 2;
            end
            // Small intervals most of the time so that fire points and interval ends
            // are reached; now and then the extremes.
            case ($urandom_range(0, 9))
                0: imin_w = 16'd0;
                1: imin_w = 16'd255;
                default: imin_w = 16'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0: dbl_w = 16'd31;
                1: dbl_w = 16'd20;
                default: dbl_w = 16'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 9))
                0: k_w = 16'd0;
                1: k_w = 16'd255;
                2: k_w = 16'($urandom_range(0, 255));
                default: k_w = 16'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 9))
                0: seed_w = 16'd0;
                1: seed_w = 16'hFFFF;
                default: seed_w = 16'($urandom_range(1, 65535));
            endcase
            write_reg(CFG_MIN_INTERVAL, imin_w);
            write_reg(CFG_DOUBLINGS, dbl_w);
            write_reg(CFG_REDUNDANCY_K, k_w);
            write_reg(CFG_IS_ROOT, ($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0);
            write_reg(CFG_LFSR_SEED, seed_w);
            setting_count++;
            @(negedge i_clk);
            // Each phase opens with a start, then mostly ticks with DIOs, DIS and some starts mixed in.
            push_event(OP_START, 16'($urandom), 16'($urandom));
            repeat (RANDOM_ITEMS - 1) begin
                pick = $urandom_range(0, 99);
                if (pick < 58)
                    op_w = OP_TICK;
                else if (pick < 82)
                    op_w = OP_DIO;
                else if (pick < 95)
                    op_w = OP_DIS;
                else
                    op_w = OP_START;
                // Ranks lean toward small values so that adoptions and consistent DIOs
                // both happen; rank 0 or 1 is rare since rank 0 shuts out further DIOs.
                case ($urandom_range(0, 19))
                    0: rank_w = 16'($urandom_range(0, 1));
                    1, 2: rank_w = 16'(16'hFFFF - $urandom_range(0, 1));
                    3, 4, 5, 6: rank_w = 16'($urandom);
                    default: rank_w = 16'($urandom_range(2, 300));
                endcase
                case ($urandom_range(0, 9))
                    0: etx_w = 16'hFFFF;
                    1: etx_w = 16'd0;
                    default: etx_w = 16'($urandom);
                endcase
                push_event(op_w, rank_w, etx_w);
            end
        end

        wait_drained();
        // Let the block settle so that any stray status item still shows up.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d events under %0d register settings, %0d status items compared.",
                 accepted_count, setting_count, checked_count);
        $display("Expected %0d DIO broadcasts, %0d DIS answers and %0d DIS multicasts.",
                 bcast_count, ucast_count, dis_count);
        if (faults == 0 && awaited_status.size() == 0)
            $display("rpl_trickle_dio_timer regression: pass");
        else
            $display("rpl_trickle_dio_timer regression: fail");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("rpl_trickle_dio_timer regression: fail");
        $finish;
    end

endmodule
